@@ src/dhcprop_pkg.sv @@
// Shared types and constants for the DHCP reply option parser.
package dhcprop_pkg;

  // Datagram layout
  localparam int unsigned OptStart        = 240;
  localparam int unsigned OptionAreaBytes = 256;
  localparam int unsigned OptLimit        = OptStart + OptionAreaBytes;
  localparam int unsigned PosW            = 9;
  localparam logic [PosW-1:0] PosMax      = 9'd511;
  localparam logic [31:0] MagicCookie     = 32'h6382_5363;

  // Option codes
  localparam logic [7:0] OptPad      = 8'd0;
  localparam logic [7:0] OptSubnet   = 8'd1;
  localparam logic [7:0] OptRouter   = 8'd3;
  localparam logic [7:0] OptDns      = 8'd6;
  localparam logic [7:0] OptMsgType  = 8'd53;
  localparam logic [7:0] OptServerId = 8'd54;
  localparam logic [7:0] OptEnd      = 8'd255;

  // Message type values accepted into the summary
  localparam logic [7:0] MsgFirst = 8'd1;
  localparam logic [7:0] MsgLast  = 8'd5;

  // Record kinds
  localparam logic [1:0] KindRouter  = 2'd0;
  localparam logic [1:0] KindDns     = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // Summary status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatShort    = 2'd1;
  localparam logic [1:0] StatBadCook  = 2'd2;
  localparam logic [1:0] StatNoEnd    = 2'd3;

  // Result queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  typedef enum logic [1:0] {
    PHASE_TYPE   = 2'd0,
    PHASE_LENGTH = 2'd1,
    PHASE_VALUE  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] ip_value;
    logic [31:0] subnet_mask;
    logic [31:0] server_id;
    logic [2:0]  message_kind;
    logic [1:0]  parse_status;
    logic        last_of_run;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       first;
    rec_t       second;
  } push_t;

endpackage

@@ src/dhcprop_if.sv @@
// Valid/ready channel interfaces for datagram bytes and parser results.
interface dhcprop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dhcprop_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] ip_value;
  logic [31:0] subnet_mask;
  logic [31:0] server_id;
  logic [2:0]  message_kind;
  logic [1:0]  parse_status;
  logic        last_of_run;

  modport source (output valid, record_kind, ip_value, subnet_mask, server_id,
                  message_kind, parse_status, last_of_run, input ready);
  modport sink   (input valid, record_kind, ip_value, subnet_mask, server_id,
                  message_kind, parse_status, last_of_run, output ready);
endinterface

@@ src/dhcprop_out_queue.sv @@
// Result queue: takes up to two records per cycle, hands out one per transfer.
module dhcprop_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhcprop_pkg::push_t    push_i,
  output logic                  room_o,
  dhcprop_out_if.source         out_o
);

  dhcprop_pkg::rec_t                 mem_q [dhcprop_pkg::QueueDepth];
  logic [dhcprop_pkg::QPtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [dhcprop_pkg::QPtrW:0]       cnt_q, cnt_d;
  logic                              pop;
  dhcprop_pkg::rec_t                 head;

  assign pop = out_o.valid & out_o.ready;

  // Write incoming records at the tail
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + dhcprop_pkg::QPtrW'(1)] <= push_i.second;
    end
  end

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q + dhcprop_pkg::QPtrW'(push_i.cnt);
    rd_d  = pop ? rd_q + dhcprop_pkg::QPtrW'(1) : rd_q;
    cnt_d = cnt_q + (dhcprop_pkg::QPtrW+1)'(push_i.cnt)
                  - (dhcprop_pkg::QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Accept a new byte only while two slots are free
  assign room_o = cnt_q <= (dhcprop_pkg::QPtrW+1)'(dhcprop_pkg::QueueDepth - 2);

  // Drive the head record
  assign head               = mem_q[rd_q];
  assign out_o.valid        = cnt_q != '0;
  assign out_o.record_kind  = head.record_kind;
  assign out_o.ip_value     = head.ip_value;
  assign out_o.subnet_mask  = head.subnet_mask;
  assign out_o.server_id    = head.server_id;
  assign out_o.message_kind = head.message_kind;
  assign out_o.parse_status = head.parse_status;
  assign out_o.last_of_run  = head.last_of_run;

endmodule

@@ src/dhcp_reply_option_parser.sv @@
// Top level: DHCP reply header capture, option walk and result generation.
//
//  channel | dir | payload                                   | transfer when
//  in_i    | in  | data_byte, last_byte                      | valid & ready
//  out_o   | out | record_kind, ip_value, subnet_mask,       | valid & ready
//          |     | server_id, message_kind, parse_status,    |
//          |     | last_of_run                               |
//
// One byte is taken per cycle while in_i.ready is high (two free queue
// slots); its state update completes at that edge and its records (at most
// two) enter the four-entry queue, so a record can leave the cycle after
// its byte. A stalled sink holds the input after three or four records.
// Reset is asynchronous and clears all parse state and the queue.
module dhcp_reply_option_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  dhcprop_in_if.sink     in_i,
  dhcprop_out_if.source  out_o
);

  logic                                  accept;
  logic                                  room;
  logic [dhcprop_pkg::PosW-1:0]          pos_q, pos_d;
  dhcprop_pkg::phase_e                   phase_q, phase_d;
  logic [7:0]                            code_q, code_d;
  logic [7:0]                            len_q, len_d;
  logic [7:0]                            cnt_q, cnt_d;
  logic [31:0]                           shift_q, shift_d;
  logic [31:0]                           offer_q, offer_d;
  logic [31:0]                           cookie_q, cookie_d;
  logic [31:0]                           subnet_q, subnet_d;
  logic [31:0]                           server_q, server_d;
  logic [2:0]                            msg_q, msg_d;
  logic                                  end_q, end_d;
  logic                                  in_opt;
  logic                                  len_ok;
  logic [7:0]                            b;
  logic [7:0]                            cnt_inc;
  logic [31:0]                           shift_inc;
  logic                                  addr_valid;
  logic [1:0]                            status;
  dhcprop_pkg::rec_t                     addr_rec, sum_rec;
  dhcprop_pkg::push_t                    push;

  assign accept = in_i.valid & in_i.ready;
  assign in_i.ready = room;
  assign b = in_i.data_byte;

  assign in_opt = (pos_q >= dhcprop_pkg::PosW'(dhcprop_pkg::OptStart))
               && (pos_q < dhcprop_pkg::PosW'(dhcprop_pkg::OptLimit))
               && (cookie_q == dhcprop_pkg::MagicCookie) && !end_q;

  assign cnt_inc   = cnt_q + 8'd1;
  assign shift_inc = {shift_q[23:0], b};

  // Check the option length against its code
  always_comb begin
    case (code_q)
      dhcprop_pkg::OptSubnet,
      dhcprop_pkg::OptServerId: len_ok = (len_q == 8'd4);
      dhcprop_pkg::OptMsgType:  len_ok = (len_q == 8'd1);
      dhcprop_pkg::OptRouter,
      dhcprop_pkg::OptDns:      len_ok = (len_q[1:0] == 2'b00);
      default:                  len_ok = 1'b0;
    endcase
  end

  // Next parse phase
  always_comb begin
    phase_d = phase_q;
    if (in_opt) begin
      case (phase_q)
        dhcprop_pkg::PHASE_TYPE: begin
          if (b != dhcprop_pkg::OptEnd && b != dhcprop_pkg::OptPad) begin
            phase_d = dhcprop_pkg::PHASE_LENGTH;
          end
        end
        dhcprop_pkg::PHASE_LENGTH: begin
          phase_d = (b == 8'd0) ? dhcprop_pkg::PHASE_TYPE : dhcprop_pkg::PHASE_VALUE;
        end
        dhcprop_pkg::PHASE_VALUE: begin
          if (cnt_inc >= len_q) begin
            phase_d = dhcprop_pkg::PHASE_TYPE;
          end
        end
        default: phase_d = dhcprop_pkg::PHASE_TYPE;
      endcase
    end
    if (in_i.last_byte) begin
      phase_d = dhcprop_pkg::PHASE_TYPE;
    end
  end

  // Datapath updates and records for one byte
  always_comb begin
    pos_d      = (pos_q < dhcprop_pkg::PosMax) ? pos_q + dhcprop_pkg::PosW'(1) : pos_q;
    code_d     = code_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    offer_d    = offer_q;
    cookie_d   = cookie_q;
    subnet_d   = subnet_q;
    server_d   = server_q;
    msg_d      = msg_q;
    end_d      = end_q;
    addr_valid = 1'b0;

    if (pos_q inside {[9'd16:9'd19]}) begin
      offer_d = {offer_q[23:0], b};
    end else if (pos_q inside {[9'd236:9'd239]}) begin
      cookie_d = {cookie_q[23:0], b};
    end else if (in_opt) begin
      case (phase_q)
        dhcprop_pkg::PHASE_TYPE: begin
          if (b == dhcprop_pkg::OptEnd) begin
            end_d = 1'b1;
          end else if (b != dhcprop_pkg::OptPad) begin
            code_d = b;
          end
        end
        dhcprop_pkg::PHASE_LENGTH: begin
          len_d   = b;
          cnt_d   = 8'd0;
          shift_d = 32'd0;
        end
        dhcprop_pkg::PHASE_VALUE: begin
          shift_d = shift_inc;
          cnt_d   = cnt_inc;
          if (len_ok) begin
            if ((code_q == dhcprop_pkg::OptRouter || code_q == dhcprop_pkg::OptDns)
                && cnt_inc[1:0] == 2'b00) begin
              addr_valid = 1'b1;
            end else if (cnt_inc == len_q) begin
              if (code_q == dhcprop_pkg::OptSubnet) begin
                subnet_d = shift_inc;
              end else if (code_q == dhcprop_pkg::OptServerId) begin
                server_d = shift_inc;
              end else if (code_q == dhcprop_pkg::OptMsgType
                           && b >= dhcprop_pkg::MsgFirst && b <= dhcprop_pkg::MsgLast) begin
                msg_d = b[2:0];
              end
            end
          end
        end
        default: ;
      endcase
    end

    // Summary status from the updated header state
    if (pos_q < dhcprop_pkg::PosW'(dhcprop_pkg::OptStart)) begin
      status = dhcprop_pkg::StatShort;
    end else if (cookie_d != dhcprop_pkg::MagicCookie) begin
      status = dhcprop_pkg::StatBadCook;
    end else if (!end_d) begin
      status = dhcprop_pkg::StatNoEnd;
    end else begin
      status = dhcprop_pkg::StatOk;
    end

    addr_rec              = '0;
    addr_rec.record_kind  = (code_q == dhcprop_pkg::OptRouter) ? dhcprop_pkg::KindRouter
                                                               : dhcprop_pkg::KindDns;
    addr_rec.ip_value     = shift_inc;
    addr_rec.last_of_run  = !in_i.last_byte;

    sum_rec.record_kind   = dhcprop_pkg::KindSummary;
    sum_rec.ip_value      = offer_d;
    sum_rec.subnet_mask   = subnet_d;
    sum_rec.server_id     = server_d;
    sum_rec.message_kind  = msg_d;
    sum_rec.parse_status  = status;
    sum_rec.last_of_run   = 1'b1;

    // Drop all parse state at the end of a datagram
    if (in_i.last_byte) begin
      pos_d    = '0;
      code_d   = '0;
      len_d    = '0;
      cnt_d    = '0;
      shift_d  = '0;
      offer_d  = '0;
      cookie_d = '0;
      subnet_d = '0;
      server_d = '0;
      msg_d    = '0;
      end_d    = 1'b0;
    end
  end

  // Pack the records for the queue
  always_comb begin
    push.first  = addr_valid ? addr_rec : sum_rec;
    push.second = sum_rec;
    if (!accept) begin
      push.cnt = 2'd0;
    end else begin
      push.cnt = 2'(addr_valid) + 2'(in_i.last_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= dhcprop_pkg::PHASE_TYPE;
      code_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      shift_q  <= '0;
      offer_q  <= '0;
      cookie_q <= '0;
      subnet_q <= '0;
      server_q <= '0;
      msg_q    <= '0;
      end_q    <= 1'b0;
    end else if (accept) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      code_q   <= code_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      offer_q  <= offer_d;
      cookie_q <= cookie_d;
      subnet_q <= subnet_d;
      server_q <= server_d;
      msg_q    <= msg_d;
      end_q    <= end_d;
    end
  end

  dhcprop_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_byte |=> pos_q == '0 && phase_q == dhcprop_pkg::PHASE_TYPE && !end_q)
    else $error("parse state not cleared after final byte");

  a_end_in_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_q |-> phase_q == dhcprop_pkg::PHASE_TYPE)
    else $error("end option seen while inside an option");

  a_addr_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_valid |-> phase_q == dhcprop_pkg::PHASE_VALUE && in_opt)
    else $error("address record outside an option value");

  a_push_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> in_i.last_byte && addr_valid)
    else $error("two records without a final address byte");
`endif

endmodule
